// ----- hdl/pmc_pkg.sv -----
// Shared types and constants for the pot-to-MIDI CC conditioner.
package pmc_pkg;

	// Register and field widths
	localparam int unsigned SHIFT_W   = 3;
	localparam int unsigned THR_W     = 15;
	localparam int unsigned MCH_W     = 4;
	localparam int unsigned CC_W      = 7;
	localparam int unsigned POT_W     = 2;
	localparam int unsigned POT_SLOTS = 4;
	localparam int unsigned CFG_IW    = 3;
	localparam int unsigned CFG_DW    = 15;
	localparam int unsigned TALLY_W   = 8;
	localparam int unsigned FX_W      = 15;
	localparam int unsigned SENT_W    = 8;
	localparam int unsigned OUT_DW    = 32;

	// Depth of the queue between the accumulator and the mapping pipe
	localparam int unsigned QUEUE_DEPTH = 4;

	// Mapping constants (8 fraction bits)
	localparam logic [7:0]      VIRT_SPAN   = 8'd159;
	localparam logic [12:0]     VIRT_LOW_FX = 13'd4096;
	localparam logic [FX_W-1:0] MIDI_TOP_FX = 15'd32512;
	localparam logic [7:0]      ROUND_HALF  = 8'd128;

	// USB-MIDI packet constants
	localparam logic [7:0]        CABLE_CIN = 8'h0B;
	localparam logic [7:0]        CC_STATUS = 8'hB0;
	localparam logic [SENT_W-1:0] NOT_SENT  = 8'hFF;

	typedef enum logic [CFG_IW-1:0] {
		CFG_SHIFT  = 3'd0,
		CFG_THRESH = 3'd1,
		CFG_MCHAN  = 3'd2,
		CFG_CC0    = 3'd3,
		CFG_CC1    = 3'd4,
		CFG_CC2    = 3'd5,
		CFG_CC3    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [SHIFT_W-1:0]              shift;
		logic [THR_W-1:0]                thresh;
		logic [MCH_W-1:0]                mchan;
		logic [POT_SLOTS-1:0][CC_W-1:0]  cc;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		shift:  3'd5,
		thresh: 15'd512,
		mchan:  4'd0,
		cc:     {7'd23, 7'd22, 7'd21, 7'd20}
	};

	typedef struct packed {
		logic [POT_W-1:0] pot_source;
		logic [7:0]       cable_header;
		logic [7:0]       status_byte;
		logic [CC_W-1:0]  ctrl_num;
		logic [CC_W-1:0]  cc_value;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ----- hdl/pmc_fifo.sv -----
// Small flop-based FIFO that decouples the accumulator from the mapping pipe.
module pmc_fifo
	import pmc_pkg::*;
#(
	parameter int unsigned WIDTH = 21,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output q_stat_t          stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == (AW+1)'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count past depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule

// ----- hdl/pmc_front.sv -----
// Front end: per-channel sample accumulation; completed sums go to the queue.
module pmc_front
	import pmc_pkg::*;
#(
	parameter int unsigned NCH = 4,
	parameter int unsigned SB  = 12,
	parameter int unsigned SW  = 19,
	parameter int unsigned IW  = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [POT_W-1:0]       pot,
	input  logic [SB-1:0]          sample,
	input  logic [SHIFT_W-1:0]     shift,
	input  q_stat_t                q_stat,
	output logic                   push,
	output logic [POT_W+SW-1:0]    push_data
);

	logic [SW-1:0]      sum_q   [NCH];
	logic [TALLY_W-1:0] tally_q [NCH];

	logic [IW-1:0]      idx;
	logic               in_range;
	logic               accept;
	logic               done;
	logic [SW-1:0]      sum_nxt;
	logic [TALLY_W-1:0] tally_nxt;
	logic [TALLY_W:0]   target;

	assign idx       = pot[IW-1:0];
	assign in_range  = (32'(pot) < NCH);
	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign sum_nxt   = sum_q[idx] + SW'(sample);
	assign tally_nxt = tally_q[idx] + 1'b1;
	assign target    = (TALLY_W+1)'(1) << shift;
	// reading is complete at the target count or past it (shift lowered)
	assign done      = ({1'b0, tally_nxt} >= target);
	assign push      = accept && in_range && done;
	assign push_data = {pot, sum_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				sum_q[i]   <= '0;
				tally_q[i] <= '0;
			end
		end else if (accept && in_range) begin
			if (done) begin
				sum_q[idx]   <= '0;
				tally_q[idx] <= '0;
			end else begin
				sum_q[idx]   <= sum_nxt;
				tally_q[idx] <= tally_nxt;
			end
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_clear_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (tally_q[$past(idx)] == '0) && (sum_q[$past(idx)] == '0))
		else $error("channel not cleared after completed reading");

endmodule

// ----- hdl/pmc_back.sv -----
// Back end: maps a completed sum to MIDI steps, applies deadband, emits CC items.
module pmc_back
	import pmc_pkg::*;
#(
	parameter int unsigned NCH = 4,
	parameter int unsigned SB  = 12,
	parameter int unsigned SW  = 19,
	parameter int unsigned IW  = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  q_stat_t             q_stat,
	input  logic [POT_W+SW-1:0] q_data,
	output logic                pop,
	input  logic                out_ready,
	output logic                out_valid,
	output result_t             res
);

	// Divisor is the full-scale ADC code 2^SB-1; two reciprocal multiplies.
	localparam longint unsigned D_VAL  = (64'd1 << SB) - 64'd1;
	localparam int unsigned     NW     = SW + 8;
	localparam int unsigned     QW     = NW - SB + 1;
	localparam longint unsigned R1_VAL = (64'd1 << NW) / D_VAL;
	localparam int unsigned     PW     = NW + QW;
	localparam int unsigned     K2     = SB + 8;
	localparam int unsigned     R2W    = 9;
	localparam longint unsigned R2_VAL = (64'd1 << K2) / D_VAL;
	localparam int unsigned     P2W    = K2 + R2W;
	localparam int unsigned     TW     = QW + 8;

	localparam logic [QW-1:0]  R1    = QW'(R1_VAL);
	localparam logic [R2W-1:0] R2    = R2W'(R2_VAL);
	localparam logic [SB:0]    D_EXT = (SB+1)'(D_VAL);

	logic adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [POT_W-1:0] pot_s1, pot_s2, pot_s3, pot_s4, pot_s5, pot_s6, pot_s7, pot_s8;

	logic [NW-1:0]   n_s1, n_s2;
	logic [PW-1:0]   p_s2;
	logic [QW-1:0]   q_s3, q_s4, q_s5, q_s6;
	logic [SB:0]     r_s3;
	logic [SB-1:0]   r_s4, r_s5;
	logic [P2W-1:0]  p2_s5;
	logic [7:0]      f_s6;
	logic [SB:0]     r2_s6;
	logic [TW-1:0]   t_s7;
	logic [FX_W-1:0] fresh_s8;

	// combinational helpers
	logic [SW-1:0]      q_sum;
	logic [NW:0]        qd_s2;
	logic [NW:0]        rfull_s2;
	logic [QW-1:0]      q0_s2;
	logic               fix_s3;
	logic [K2-1:0]      m_s4;
	logic [K2-1:0]      m_s5;
	logic [7:0]         f0_s5;
	logic [K2-1:0]      r2full_s5;
	logic               fix_s6;
	logic [TW-1:0]      qv_s7;
	logic [TW-1:0]      dv_s7;
	logic [FX_W-1:0]    fresh_s7;

	logic [FX_W-1:0]    fx_state_q [NCH];
	logic [SENT_W-1:0]  last_q     [NCH];
	logic [IW-1:0]      idx_s8;
	logic [FX_W-1:0]    stab;
	logic [FX_W-1:0]    diff;
	logic [FX_W-1:0]    stab_nxt;
	logic [FX_W:0]      rnd_full;
	logic [SENT_W-1:0]  rnd;
	logic               send;
	logic               res_valid_q;
	result_t            res_q;

	// whole pipe moves unless a result is waiting and not taken
	assign adv = !(res_valid_q && !out_ready);
	assign pop = adv && !q_stat.empty;

	assign q_sum = q_data[SW-1:0];

	// s2 -> s3: quotient estimate and remainder
	assign q0_s2    = p_s2[NW +: QW];
	assign qd_s2    = {q0_s2, {SB{1'b0}}} - (NW+1)'(q0_s2);
	assign rfull_s2 = {1'b0, n_s2} - qd_s2;

	// s3 -> s4: one correction step
	assign fix_s3 = (r_s3 >= D_EXT);

	// s4 -> s5: fraction of the remainder, 8 bits
	assign m_s4 = {r_s4, 8'b0};

	// s5 -> s6
	assign m_s5      = {r_s5, 8'b0};
	assign f0_s5     = p2_s5[K2 +: 8];
	assign r2full_s5 = m_s5 - ({f0_s5, {SB{1'b0}}} - K2'(f0_s5));

	// s6 -> s7
	assign fix_s6 = (r2_s6 >= D_EXT);

	// s7 -> s8: divide by 2^shift, offset by the virtual low end, clamp
	assign qv_s7 = t_s7 >> cfg.shift;
	assign dv_s7 = qv_s7 - TW'(VIRT_LOW_FX);
	always_comb begin
		if (qv_s7 <= TW'(VIRT_LOW_FX)) begin
			fresh_s7 = '0;
		end else if (dv_s7 > TW'(MIDI_TOP_FX)) begin
			fresh_s7 = MIDI_TOP_FX;
		end else begin
			fresh_s7 = dv_s7[FX_W-1:0];
		end
	end

	// s8: deadband, rounding and change detect against per-channel state
	assign idx_s8   = pot_s8[IW-1:0];
	assign stab     = fx_state_q[idx_s8];
	assign diff     = (fresh_s8 >= stab) ? fresh_s8 - stab : stab - fresh_s8;
	assign stab_nxt = (diff > cfg.thresh) ? fresh_s8 : stab;
	assign rnd_full = {1'b0, stab_nxt} + (FX_W+1)'(ROUND_HALF);
	assign rnd      = rnd_full[FX_W -: SENT_W];
	assign send     = (rnd != last_q[idx_s8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NCH; i++) begin
				fx_state_q[i] <= '0;
				last_q[i]     <= NOT_SENT;
			end
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			res_valid_q <= v_s8 && send;
			if (v_s8) begin
				fx_state_q[idx_s8] <= stab_nxt;
				if (send) begin
					last_q[idx_s8] <= rnd;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pot_s1 <= q_data[SW +: POT_W];
			n_s1   <= NW'(q_sum) * NW'(VIRT_SPAN);

			pot_s2 <= pot_s1;
			n_s2   <= n_s1;
			p_s2   <= PW'(n_s1) * PW'(R1);

			pot_s3 <= pot_s2;
			q_s3   <= q0_s2;
			r_s3   <= rfull_s2[SB:0];

			pot_s4 <= pot_s3;
			q_s4   <= q_s3 + QW'(fix_s3);
			r_s4   <= fix_s3 ? SB'(r_s3 - D_EXT) : r_s3[SB-1:0];

			pot_s5 <= pot_s4;
			q_s5   <= q_s4;
			r_s5   <= r_s4;
			p2_s5  <= P2W'(m_s4) * P2W'(R2);

			pot_s6 <= pot_s5;
			q_s6   <= q_s5;
			f_s6   <= f0_s5;
			r2_s6  <= r2full_s5[SB:0];

			pot_s7 <= pot_s6;
			t_s7   <= {q_s6, f_s6 + 8'(fix_s6)};

			pot_s8   <= pot_s7;
			fresh_s8 <= fresh_s7;

			if (v_s8 && send) begin
				res_q.pot_source   <= pot_s8;
				res_q.cable_header <= CABLE_CIN;
				res_q.status_byte  <= CC_STATUS | {4'b0, cfg.mchan};
				res_q.ctrl_num     <= cfg.cc[pot_s8];
				res_q.cc_value     <= rnd[CC_W-1:0];
			end
		end
	end

	assign out_valid = res_valid_q;
	assign res       = res_q;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (r_s3 < (SB+1)'(2 * D_VAL)))
		else $error("reciprocal estimate off by more than one");

	a_sent_matches: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (last_q[res_q.pot_source[IW-1:0]] == {1'b0, res_q.cc_value}))
		else $error("pending item disagrees with last sent value");

endmodule

// ----- hdl/pot_to_midi_cc_conditioner_core.sv -----
// Top level of the pot-to-MIDI CC conditioner: config registers, front, queue, back.
//
// Takes tagged ADC samples one item per clock while the queue has room, sums them
// per pot channel until 2^oversample_shift samples have arrived, and pushes
// the completed sum into a four-entry queue for an eight-stage mapping pipe, which
// divides by the full-scale ADC code (two reciprocal multiplies with one
// correction step each), scales onto -16..143 MIDI steps with 8 fraction bits,
// clamps to 0..127, applies the deadband against the channel's stable value,
// rounds, and emits a USB-MIDI control-change item when the rounded value
// differs from the last one sent (the first reading of each channel always
// sends). Sustained rate is one input item per clock while the queue has room;
// a result is offered from the output register once the sample that completed
// its reading has gone through the queue and the mapping pipe. A held result stalls
// only the mapping pipe; input keeps flowing until the queue is full. Samples
// tagged with a channel at or above CHANNELS are dropped without effect.
// Configuration writes take effect on the next clock and should be made
// while no reading is in flight.
module pot_to_midi_cc_conditioner_core
	import pmc_pkg::*;
#(
	parameter int unsigned CHANNELS    = 4,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input samples
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
	input  logic [POT_W-1:0]                       s_axis_tuser,  // pot_index
	// CC items
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// cable_header, status_byte, ctrl_num, cc_value
	output logic [OUT_DW-1:0]                      m_axis_tdata,
	output logic [POT_W-1:0]                       m_axis_tuser,  // pot_source
	// register writes
	input  logic                                   cfg_we,
	input  logic [CFG_IW-1:0]                      cfg_index,
	input  logic [CFG_DW-1:0]                      cfg_data
);

	// only four channels can be named by the 2-bit tag
	localparam int unsigned NCH = (CHANNELS < POT_SLOTS) ? CHANNELS : POT_SLOTS;
	localparam int unsigned IW  = (NCH > 1) ? $clog2(NCH) : 1;
	// sum of up to 2^(max shift) samples
	localparam int unsigned SW  = SAMPLE_BITS + (1 << SHIFT_W) - 1;
	localparam int unsigned QEW = POT_W + SW;

	cfg_t             cfg_q;
	q_stat_t          q_stat;
	logic             push;
	logic [QEW-1:0]   push_data;
	logic             pop;
	logic [QEW-1:0]   q_data;
	result_t          res;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SHIFT:  cfg_q.shift  <= cfg_data[SHIFT_W-1:0];
				CFG_THRESH: cfg_q.thresh <= cfg_data[THR_W-1:0];
				CFG_MCHAN:  cfg_q.mchan  <= cfg_data[MCH_W-1:0];
				CFG_CC0:    cfg_q.cc[0]  <= cfg_data[CC_W-1:0];
				CFG_CC1:    cfg_q.cc[1]  <= cfg_data[CC_W-1:0];
				CFG_CC2:    cfg_q.cc[2]  <= cfg_data[CC_W-1:0];
				CFG_CC3:    cfg_q.cc[3]  <= cfg_data[CC_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	// Accumulate samples; push (pot, sum) when a reading completes.
	pmc_front #(
		.NCH (NCH),
		.SB  (SAMPLE_BITS),
		.SW  (SW),
		.IW  (IW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pot       (s_axis_tuser),
		.sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
		.shift     (cfg_q.shift),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Completed readings waiting for the mapping pipe.
	pmc_fifo #(
		.WIDTH (QEW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (q_data),
		.stat    (q_stat)
	);

	// Map, deadband, round, and emit.
	pmc_back #(
		.NCH (NCH),
		.SB  (SAMPLE_BITS),
		.SW  (SW),
		.IW  (IW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.q_data    (q_data),
		.pop       (pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.res       (res)
	);

	// lowest bits first: header, status, controller, value, two pad bits
	assign m_axis_tdata = {2'b00, res.cc_value, res.ctrl_num,
		res.status_byte, res.cable_header};
	assign m_axis_tuser = res.pot_source;

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the pot-to-MIDI CC conditioner core.
module tb;
	import pmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam time         CLK_PERIOD  = 4ns;
	localparam int          RESET_TICKS = 5;
	// quiet cycles before a register write and at the end: covers pipe depth plus queue
	localparam int          SETTLE      = 40;
	// longest receiver hold-off, used once to back the block up into its input
	localparam int          HOLD_CYCLES = 300;
	// cycles with no handshake on either side before the run is declared hung
	localparam int          STALL_LIMIT = 2000;
	localparam int          PHASES      = 8;

	// mapping arithmetic, 8 fraction bits
	localparam int unsigned ADC_FULL    = 4095;
	localparam int unsigned SPAN_STEPS  = 159;
	localparam int unsigned LOW_OFS_FX  = 4096;
	localparam int unsigned TOP_FX      = 32512;
	localparam logic [7:0]  USB_CIN_CC  = 8'h0B;
	localparam logic [7:0]  STATUS_CC   = 8'hB0;
	localparam logic [7:0]  NEVER_SENT  = 8'hFF;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	// one row of the directed part: a register write or a sample
	typedef struct {
		row_kind_t   kind;
		cfg_idx_t    reg_idx;
		logic [14:0] reg_val;
		logic [1:0]  pot;
		logic [11:0] smp;
		bit          typed;   // want holds a hand-derived CC item
		result_t     want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // sample
	logic [1:0]  s_axis_tuser = '0;   // pot_index
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // cable_header, status_byte, ctrl_num, cc_value
	logic [1:0]  m_axis_tuser;        // pot_source
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = CFG_SHIFT;
	logic [14:0] cfg_data = '0;

	// predictor state: one copy of the register file and per-pot channel state
	cfg_t        shadow_cfg;
	logic [18:0] pot_sum   [4];
	logic [7:0]  pot_tally [4];
	logic [14:0] pot_stable[4];
	logic [7:0]  pot_last  [4];

	result_t     pending_msgs[$];   // CC items predicted, not yet seen
	stim_row_t   stim_rows[$];
	int          knob_pos[4];

	int          errors = 0;
	int          samples_accepted = 0;
	int          msgs_checked = 0;
	int          reg_writes = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          rx_hold_left = 0;
	int          quiet_cycles = 0;

	pot_to_midi_cc_conditioner_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Accumulate one sample; on a completed reading map the average onto
	// -16..143 steps, clamp to 0..127, apply the deadband and report a CC item
	// when the rounded value moved away from the last one sent.
	function automatic bit predict_cc(input logic [1:0] pot, input logic [11:0] smp,
			output result_t msg);
		longint unsigned num, den, q;
		logic [14:0]     fresh;
		logic [14:0]     diff;
		logic [7:0]      rounded;
		msg = '0;
		pot_sum[pot] = pot_sum[pot] + smp;
		pot_tally[pot] = pot_tally[pot] + 8'd1;
		// a tally already past a shrunken count completes on this sample too
		if (int'(pot_tally[pot]) < (1 << shadow_cfg.shift))
			return 1'b0;
		num = 64'(pot_sum[pot]);
		num = num * SPAN_STEPS * 256;
		den = 64'(ADC_FULL);
		den = den << shadow_cfg.shift;
		q = num / den;
		if (q <= LOW_OFS_FX) begin
			fresh = '0;
		end else begin
			q = q - LOW_OFS_FX;
			if (q > TOP_FX)
				q = 64'(TOP_FX);
			fresh = q[14:0];
		end
		pot_sum[pot] = '0;
		pot_tally[pot] = '0;
		diff = (fresh > pot_stable[pot]) ? fresh - pot_stable[pot] : pot_stable[pot] - fresh;
		if (diff > shadow_cfg.thresh)
			pot_stable[pot] = fresh;
		rounded = 8'((16'(pot_stable[pot]) + 16'd128) >> 8);
		if (rounded == pot_last[pot])
			return 1'b0;
		pot_last[pot] = rounded;
		msg.pot_source   = pot;
		msg.cable_header = USB_CIN_CC;
		msg.status_byte  = STATUS_CC | {4'b0, shadow_cfg.mchan};
		msg.ctrl_num     = shadow_cfg.cc[pot];
		msg.cc_value     = rounded[6:0];
		return 1'b1;
	endfunction

	function automatic stim_row_t reg_row(input cfg_idx_t idx, input int val);
		stim_row_t r;
		r = '{kind: ROW_WRITE, reg_idx: idx, reg_val: val[14:0], pot: '0, smp: '0,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic stim_row_t smp_row(input int pot, input int smp);
		stim_row_t r;
		r = '{kind: ROW_SAMPLE, reg_idx: CFG_SHIFT, reg_val: '0, pot: pot[1:0],
			smp: smp[11:0], typed: 1'b0, want: '0};
		return r;
	endfunction

	// sample row whose CC item is written out by hand
	function automatic stim_row_t smp_msg_row(input int pot, input int smp, input int status,
			input int ccn, input int val);
		stim_row_t r;
		r = smp_row(pot, smp);
		r.typed = 1'b1;
		r.want = '{pot_source: pot[1:0], cable_header: USB_CIN_CC, status_byte: status[7:0],
			ctrl_num: ccn[6:0], cc_value: val[6:0]};
		return r;
	endfunction

	// Offer one sample from the falling edge on, idling first at the phase's rate;
	// returns at the rising edge where it was taken.
	task automatic offer_sample(input logic [1:0] pot, input logic [11:0] smp,
			input bit typed, input result_t want);
		result_t msg;
		bit      emitted;
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, smp};
		s_axis_tuser  <= pot;
		do
			@(posedge clk);
		while (!s_axis_tready);
		samples_accepted++;
		emitted = predict_cc(pot, smp, msg);
		if (typed)
			pending_msgs.push_back(want);
		else if (emitted)
			pending_msgs.push_back(msg);
	endtask

	// Stop offering, let every predicted item drain, then give the pipe time
	// to finish readings that produce no item.
	task automatic drain_and_settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [14:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_SHIFT:  shadow_cfg.shift  = val[2:0];
			CFG_THRESH: shadow_cfg.thresh = val[14:0];
			CFG_MCHAN:  shadow_cfg.mchan  = val[3:0];
			CFG_CC0:    shadow_cfg.cc[0]  = val[6:0];
			CFG_CC1:    shadow_cfg.cc[1]  = val[6:0];
			CFG_CC2:    shadow_cfg.cc[2]  = val[6:0];
			CFG_CC3:    shadow_cfg.cc[3]  = val[6:0];
			default: ;
		endcase
	endtask

	// Receiver: stalls at the phase's rate, or holds off entirely while a
	// requested hold-off is counting down.
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Output checker: every item taken is compared with the oldest prediction.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pot_source   = m_axis_tuser;
			got.cable_header = m_axis_tdata[7:0];
			got.status_byte  = m_axis_tdata[15:8];
			got.ctrl_num     = m_axis_tdata[22:16];
			got.cc_value     = m_axis_tdata[29:23];
			if (pending_msgs.size() == 0) begin
				$error("unexpected CC item: pot %0d value %0d", got.pot_source, got.cc_value);
				errors++;
			end else begin
				want = pending_msgs.pop_front();
				msgs_checked++;
				if (got.pot_source !== want.pot_source) begin
					$error("pot_source: expected %0d, got %0d", want.pot_source, got.pot_source);
					errors++;
				end
				if (got.cable_header !== want.cable_header) begin
					$error("cable_header: expected 0x%02h, got 0x%02h", want.cable_header,
						got.cable_header);
					errors++;
				end
				if (got.status_byte !== want.status_byte) begin
					$error("status_byte: expected 0x%02h, got 0x%02h", want.status_byte,
						got.status_byte);
					errors++;
				end
				if (got.ctrl_num !== want.ctrl_num) begin
					$error("ctrl_num: expected %0d, got %0d", want.ctrl_num, got.ctrl_num);
					errors++;
				end
				if (got.cc_value !== want.cc_value) begin
					$error("cc_value: expected %0d, got %0d", want.cc_value, got.cc_value);
					errors++;
				end
			end
		end
	end

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d CC items outstanding",
				quiet_cycles, pending_msgs.size());
			$display("** pot_to_midi_cc_conditioner_core: FAILED **");
			$finish;
		end
	end

	initial begin
		int          ph, n, i, v;
		logic [1:0]  pot;
		logic [11:0] smp;
		logic [14:0] reg_vals[7];

		shadow_cfg = CFG_RESET;
		for (i = 0; i < 4; i++) begin
			pot_sum[i]    = '0;
			pot_tally[i]  = '0;
			pot_stable[i] = '0;
			pot_last[i]   = NEVER_SENT;
			knob_pos[i]   = $urandom_range(0, ADC_FULL);
		end

		// Directed part. Shift 0 makes every sample a full reading.
		stim_rows.push_back(reg_row(CFG_SHIFT, 0));
		// full scale and zero: first reading of a channel always sends
		stim_rows.push_back(smp_msg_row(0, 4095, 'hB0, 20, 127));
		stim_rows.push_back(smp_msg_row(1, 0, 'hB0, 21, 0));
		stim_rows.push_back(smp_row(2, 2048));
		stim_rows.push_back(smp_msg_row(3, 1, 'hB0, 23, 0));
		// same rounded value again: nothing sent
		stim_rows.push_back(smp_row(0, 4095));
		stim_rows.push_back(smp_msg_row(0, 0, 'hB0, 20, 0));
		// inside the default deadband
		stim_rows.push_back(smp_row(2, 2049));
		// widest deadband freezes the stable value
		stim_rows.push_back(reg_row(CFG_THRESH, 32767));
		stim_rows.push_back(smp_row(2, 4095));
		stim_rows.push_back(smp_row(1, 4095));
		// no deadband: one-code moves reach the rounding
		stim_rows.push_back(reg_row(CFG_THRESH, 0));
		stim_rows.push_back(smp_row(2, 2060));
		stim_rows.push_back(smp_row(2, 2061));
		stim_rows.push_back(reg_row(CFG_MCHAN, 15));
		stim_rows.push_back(reg_row(CFG_CC0, 127));
		stim_rows.push_back(reg_row(CFG_CC1, 0));
		stim_rows.push_back(reg_row(CFG_CC2, 64));
		stim_rows.push_back(reg_row(CFG_CC3, 1));
		stim_rows.push_back(smp_msg_row(0, 4095, 'hBF, 127, 127));
		stim_rows.push_back(smp_msg_row(1, 4095, 'hBF, 0, 127));
		// shift shrinks mid-reading: tally 3 is past the new count of 2, so the
		// next sample completes a reading of four full-scale codes over two
		stim_rows.push_back(reg_row(CFG_SHIFT, 7));
		stim_rows.push_back(smp_row(3, 4095));
		stim_rows.push_back(smp_row(3, 4095));
		stim_rows.push_back(smp_row(3, 4095));
		stim_rows.push_back(reg_row(CFG_SHIFT, 1));
		stim_rows.push_back(smp_msg_row(3, 4095, 'hBF, 1, 127));
		stim_rows.push_back(smp_row(3, 0));
		stim_rows.push_back(smp_row(3, 0));
		stim_rows.push_back(reg_row(CFG_SHIFT, 2));
		stim_rows.push_back(smp_row(2, 4000));
		stim_rows.push_back(smp_row(2, 4010));
		stim_rows.push_back(smp_row(2, 4020));
		stim_rows.push_back(smp_row(2, 4030));

		repeat (RESET_TICKS) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (stim_rows[k]) begin
			if (stim_rows[k].kind == ROW_WRITE) begin
				if (k == 0 || stim_rows[k - 1].kind != ROW_WRITE)
					drain_and_settle();
				write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_val);
			end else begin
				offer_sample(stim_rows[k].pot, stim_rows[k].smp, stim_rows[k].typed,
					stim_rows[k].want);
			end
		end

		// Random phases: a new register set each, idling modes in rotation
		// (none, sender, receiver, both). Partial sums carry across phases, so
		// shift changes land on half-finished readings as well.
		for (ph = 0; ph < PHASES; ph++) begin
			drain_and_settle();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			reg_vals[CFG_SHIFT]  = 15'($urandom_range(0, 3));
			reg_vals[CFG_THRESH] = 15'($urandom_range(0, 1023));
			reg_vals[CFG_MCHAN]  = 15'($urandom_range(0, 15));
			for (i = CFG_CC0; i <= CFG_CC3; i++)
				reg_vals[i] = 15'($urandom_range(0, 127));
			case (ph)
				0: reg_vals = '{0, 0, 0, 0, 0, 0, 0};
				1: reg_vals = '{7, 0, 15, 127, 127, 127, 127};
				2: begin reg_vals[CFG_SHIFT] = 1; reg_vals[CFG_THRESH] = 32767; end
				4: begin reg_vals[CFG_SHIFT] = 0; reg_vals[CFG_THRESH] = 0; end
				default: ;
			endcase
			for (i = 0; i < 7; i++)
				write_reg(cfg_idx_t'(i), reg_vals[i]);
			// long receiver hold-off while samples keep coming: fills the queue
			if (ph == 4)
				rx_hold_left = HOLD_CYCLES;
			n = (ph == 1) ? 180 : 75;
			for (i = 0; i < n; i++) begin
				// the deepest shift gets most samples on one pot to finish a reading
				if (ph == 1 && $urandom_range(0, 99) < 85)
					pot = 2'd2;
				else
					pot = 2'($urandom_range(0, 3));
				v = $urandom_range(0, 99);
				if (v < 15) begin
					smp = 12'($urandom_range(0, ADC_FULL));
				end else if (v < 25) begin
					smp = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
				end else begin
					// a knob resting with ADC noise, moved now and then
					if (v < 30)
						knob_pos[pot] = $urandom_range(0, ADC_FULL);
					v = knob_pos[pot] + $urandom_range(0, 48) - 24;
					if (v < 0)
						v = 0;
					if (v > ADC_FULL)
						v = ADC_FULL;
					smp = v[11:0];
				end
				offer_sample(pot, smp, 1'b0, '0);
			end
		end

		drain_and_settle();
		$display("Ran %0d samples over %0d register writes, %0d random phases with idling",
			samples_accepted, reg_writes, PHASES);
		$display("and one long output hold-off; %0d CC items compared, %0d mismatches.",
			msgs_checked, errors);
		if (errors == 0)
			$display("** pot_to_midi_cc_conditioner_core: PASSED **");
		else
			$display("** pot_to_midi_cc_conditioner_core: FAILED **");
		$finish;
	end

endmodule
